>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the int8 GEMM core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> rtl/core/i8gemm_pkg.sv
// ---------------------------------------------------------------------------
// i8gemm_pkg
// Types, sizes and codes shared by the int8 GEMM dequantization core.
// ---------------------------------------------------------------------------
package i8gemm_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int MAX_DEPTH    = 256;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int DEP_W        = $clog2(MAX_DEPTH);
    localparam int WADDR_W      = CH_W + DEP_W;
    localparam int DCNT_W       = 9;   // depth_used register width
    localparam int CCNT_W       = 5;   // channels_used register width
    localparam int ROW_W        = 16;
    localparam int SCALE_W      = 32;
    localparam int VAL_W        = 8;
    localparam int SUM_W        = 24;
    localparam int MAG_W        = 23;  // |dot product| never exceeds 2^22
    localparam int PROD_W       = 2 * SCALE_W;
    localparam int PART_W       = MAG_W + SCALE_W;
    localparam int RSUM_W       = PART_W + 1;
    localparam int DQ_W         = 48;
    localparam int CFG_IDX_W    = 2;

    localparam logic [RSUM_W-1:0] SAT_POS = RSUM_W'((64'd1 << (DQ_W - 1)) - 64'd1);
    localparam logic [RSUM_W-1:0] SAT_MAG = RSUM_W'(64'd1 << (DQ_W - 1));

    localparam logic [DCNT_W-1:0] DEPTH_RST = DCNT_W'(MAX_DEPTH);
    localparam logic [CCNT_W-1:0] CHANS_RST = CCNT_W'(MAX_CHANNELS);
    localparam logic [ROW_W-1:0]  ROWS_RST  = ROW_W'(1);
    localparam logic [SCALE_W-1:0] ASCALE_RST = SCALE_W'(32'h0100_0000);

    typedef enum logic [1:0] {
        OP_LOAD_WEIGHT = 2'd0,
        OP_LOAD_SCALE  = 2'd1,
        OP_ACTIVATION  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH_USED    = 2'd0,
        CFG_CHANNELS_USED = 2'd1,
        CFG_ROWS          = 2'd2,
        CFG_ACT_SCALE     = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DRAIN,
        ST_MAG,
        ST_LO,
        ST_HI,
        ST_SUM,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]               op;
        logic [CH_W-1:0]          channel;
        logic [DEP_W-1:0]         depth_index;
        logic signed [VAL_W-1:0]  value;
        logic [SCALE_W-1:0]       scale_value;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]         row_number;
        logic [CH_W-1:0]          out_channel;
        logic signed [SUM_W-1:0]  dot_sum;
        logic signed [DQ_W-1:0]   dequantized;
        logic                     row_last;
        logic                     matrix_last;
    } t_out_item;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [DCNT_W-1:0]  depth;
        logic [CCNT_W-1:0]  chans;
        logic [ROW_W-1:0]   rows;
        logic [SCALE_W-1:0] tensor_scale;
    } t_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic               act_we;
        logic [DEP_W-1:0]   act_waddr;
        logic               wgt_we;
        logic               scale_we;
        logic               rd_en;
        logic [CH_W-1:0]    rd_ch;
        logic [DEP_W-1:0]   rd_k;
        logic               acc_clr;
        logic               mag_en;
        logic               lo_en;
        logic               hi_en;
        logic               sum_en;
        logic               emit;
        logic [ROW_W-1:0]   row_number;
        logic [CH_W-1:0]    out_channel;
        logic               row_last;
        logic               matrix_last;
    } t_dp_cmd;

endpackage

>>> rtl/core/i8gemm_cfg.sv
// ---------------------------------------------------------------------------
// i8gemm_cfg
// Configuration registers with clamping to the usable ranges.
// ---------------------------------------------------------------------------
module i8gemm_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [i8gemm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [i8gemm_pkg::SCALE_W-1:0]    i_cfg_wdata,
    output i8gemm_pkg::t_cfg                  o_cfg
);

    logic [i8gemm_pkg::DCNT_W-1:0]  r_depth_used;
    logic [i8gemm_pkg::CCNT_W-1:0]  r_channels_used;
    logic [i8gemm_pkg::ROW_W-1:0]   r_rows_per_matrix;
    logic [i8gemm_pkg::SCALE_W-1:0] r_act_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_used      <= i8gemm_pkg::DEPTH_RST;
            r_channels_used   <= i8gemm_pkg::CHANS_RST;
            r_rows_per_matrix <= i8gemm_pkg::ROWS_RST;
            r_act_scale       <= i8gemm_pkg::ASCALE_RST;
        end else if (i_cfg_we) begin
            case (i8gemm_pkg::t_cfg_idx'(i_cfg_idx))
                i8gemm_pkg::CFG_DEPTH_USED: begin
                    r_depth_used <= i_cfg_wdata[i8gemm_pkg::DCNT_W-1:0];
                end
                i8gemm_pkg::CFG_CHANNELS_USED: begin
                    r_channels_used <= i_cfg_wdata[i8gemm_pkg::CCNT_W-1:0];
                end
                i8gemm_pkg::CFG_ROWS: begin
                    r_rows_per_matrix <= i_cfg_wdata[i8gemm_pkg::ROW_W-1:0];
                end
                i8gemm_pkg::CFG_ACT_SCALE: begin
                    r_act_scale <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Zero acts as one, anything above the store size acts as the store size
    always_comb begin
        if (r_depth_used == '0) begin
            o_cfg.depth = i8gemm_pkg::DCNT_W'(1);
        end else if (r_depth_used > i8gemm_pkg::DEPTH_RST) begin
            o_cfg.depth = i8gemm_pkg::DEPTH_RST;
        end else begin
            o_cfg.depth = r_depth_used;
        end

        if (r_channels_used == '0) begin
            o_cfg.chans = i8gemm_pkg::CCNT_W'(1);
        end else if (r_channels_used > i8gemm_pkg::CHANS_RST) begin
            o_cfg.chans = i8gemm_pkg::CHANS_RST;
        end else begin
            o_cfg.chans = r_channels_used;
        end

        if (r_rows_per_matrix == '0) begin
            o_cfg.rows = i8gemm_pkg::ROW_W'(1);
        end else begin
            o_cfg.rows = r_rows_per_matrix;
        end

        o_cfg.tensor_scale = r_act_scale;
    end

endmodule

>>> rtl/core/i8gemm_dp.sv
// ---------------------------------------------------------------------------
// i8gemm_dp
// Weight, scale and activation stores, MAC accumulator and the multi-cycle
// dequantization path with the result register.
// ---------------------------------------------------------------------------
module i8gemm_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  i8gemm_pkg::t_cfg        i_cfg,
    input  i8gemm_pkg::t_in_item    i_item,
    input  i8gemm_pkg::t_dp_cmd     i_cmd,
    output i8gemm_pkg::t_out_item   o_result,
    output logic                    o_result_valid
);

    localparam int WDEPTH = i8gemm_pkg::MAX_CHANNELS * i8gemm_pkg::MAX_DEPTH;

    logic [i8gemm_pkg::VAL_W-1:0]   r_wgt_mem [WDEPTH];
    logic [i8gemm_pkg::VAL_W-1:0]   r_act_mem [i8gemm_pkg::MAX_DEPTH];
    logic [i8gemm_pkg::SCALE_W-1:0] r_scale [i8gemm_pkg::MAX_CHANNELS];

    logic signed [i8gemm_pkg::VAL_W-1:0]  r_wgt_q;
    logic signed [i8gemm_pkg::VAL_W-1:0]  r_act_q;
    logic                                 r_rd_v;
    logic signed [i8gemm_pkg::SUM_W-1:0]  r_acc;
    logic [i8gemm_pkg::PROD_W-1:0]        r_p;
    logic [i8gemm_pkg::MAG_W-1:0]         r_mag;
    logic                                 r_neg;
    logic [i8gemm_pkg::PART_W-1:0]        r_lo;
    logic [i8gemm_pkg::PART_W-1:0]        r_mid;
    logic [i8gemm_pkg::RSUM_W-1:0]        r_rsum;
    i8gemm_pkg::t_out_item                r_out;
    logic                                 r_out_v;

    logic signed [2*i8gemm_pkg::VAL_W-1:0] mac_prod;
    logic [i8gemm_pkg::SUM_W-1:0]          acc_neg;
    logic [i8gemm_pkg::RSUM_W-1:0]         sat_val;
    logic [i8gemm_pkg::DQ_W-1:0]           dq_val;

    // Stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.wgt_we) begin
            r_wgt_mem[{i_item.channel, i_item.depth_index}] <= i_item.value;
        end
        if (i_cmd.rd_en) begin
            r_wgt_q <= r_wgt_mem[{i_cmd.rd_ch, i_cmd.rd_k}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.act_we) begin
            r_act_mem[i_cmd.act_waddr] <= i_item.value;
        end
        if (i_cmd.rd_en) begin
            r_act_q <= r_act_mem[i_cmd.rd_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale_we) begin
            r_scale[i_item.channel] <= i_item.scale_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_rd_v  <= i_cmd.rd_en;
            r_out_v <= i_cmd.emit;
        end
    end

    assign mac_prod = r_act_q * r_wgt_q;
    assign acc_neg  = '0 - r_acc;

    // Saturate the rounded magnitude, then apply the sign
    always_comb begin
        if (r_neg) begin
            sat_val = (r_rsum > i8gemm_pkg::SAT_MAG) ? i8gemm_pkg::SAT_MAG : r_rsum;
            dq_val = '0 - sat_val[i8gemm_pkg::DQ_W-1:0];
        end else begin
            sat_val = (r_rsum > i8gemm_pkg::SAT_POS) ? i8gemm_pkg::SAT_POS : r_rsum;
            dq_val = sat_val[i8gemm_pkg::DQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
            r_p   <= i_cfg.tensor_scale * r_scale[i_cmd.rd_ch];
        end else if (r_rd_v) begin
            r_acc <= r_acc + i8gemm_pkg::SUM_W'(mac_prod);
        end

        if (i_cmd.mag_en) begin
            r_neg <= r_acc[i8gemm_pkg::SUM_W-1];
            r_mag <= r_acc[i8gemm_pkg::SUM_W-1] ? acc_neg[i8gemm_pkg::MAG_W-1:0]
                                                 : r_acc[i8gemm_pkg::MAG_W-1:0];
        end
        if (i_cmd.lo_en) begin
            r_lo <= r_mag * r_p[i8gemm_pkg::SCALE_W-1:0];
        end
        if (i_cmd.hi_en) begin
            r_mid <= r_mag * r_p[i8gemm_pkg::PROD_W-1:i8gemm_pkg::SCALE_W];
        end
        // Round to nearest: keep the high part of the low product plus its round bit
        if (i_cmd.sum_en) begin
            r_rsum <= i8gemm_pkg::RSUM_W'(r_mid)
                    + i8gemm_pkg::RSUM_W'(r_lo[i8gemm_pkg::PART_W-1:i8gemm_pkg::SCALE_W])
                    + i8gemm_pkg::RSUM_W'(r_lo[i8gemm_pkg::SCALE_W-1]);
        end
        if (i_cmd.emit) begin
            r_out.row_number  <= i_cmd.row_number;
            r_out.out_channel <= i_cmd.out_channel;
            r_out.dot_sum     <= r_acc;
            r_out.dequantized <= dq_val;
            r_out.row_last    <= i_cmd.row_last;
            r_out.matrix_last <= i_cmd.matrix_last;
        end
    end

    assign o_result       = r_out;
    assign o_result_valid = r_out_v;

endmodule

>>> rtl/core/i8gemm_ctrl.sv
// ---------------------------------------------------------------------------
// i8gemm_ctrl
// Sequencer: element and row counters, per-channel MAC sweep and the
// dequantization steps.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i8gemm_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  i8gemm_pkg::t_cfg        i_cfg,
    input  logic                    i_start,
    input  logic [1:0]              i_op,
    output logic                    o_busy,
    output i8gemm_pkg::t_dp_cmd     o_cmd
);

    i8gemm_pkg::t_state r_state, n_state;
    logic [i8gemm_pkg::DCNT_W-1:0] r_ec, n_ec;
    logic [i8gemm_pkg::ROW_W-1:0]  r_rc, n_rc;
    logic [i8gemm_pkg::ROW_W-1:0]  r_row, n_row;
    logic                          r_mlast, n_mlast;
    logic [i8gemm_pkg::DCNT_W-1:0] r_k, n_k;
    logic [i8gemm_pkg::CCNT_W-1:0] r_n, n_n;

    logic                          accept;
    logic                          is_act;
    logic [i8gemm_pkg::DCNT_W-1:0] ec_eff;
    logic [i8gemm_pkg::DCNT_W-1:0] ec_inc;
    logic [i8gemm_pkg::ROW_W-1:0]  rc_eff;
    logic [i8gemm_pkg::ROW_W:0]    rc_inc;
    logic [i8gemm_pkg::DCNT_W-1:0] k_inc;
    logic [i8gemm_pkg::CCNT_W-1:0] n_inc;

    assign o_busy = (r_state != i8gemm_pkg::ST_IDLE);
    assign accept = i_start && !o_busy;
    assign is_act = accept && (i_op == i8gemm_pkg::OP_ACTIVATION);

    // A shrunk depth drops the partial row; a shrunk row count wraps first
    assign ec_eff = (r_ec >= i_cfg.depth) ? '0 : r_ec;
    assign ec_inc = ec_eff + i8gemm_pkg::DCNT_W'(1);
    assign rc_eff = (r_rc >= i_cfg.rows) ? '0 : r_rc;
    assign rc_inc = {1'b0, rc_eff} + (i8gemm_pkg::ROW_W+1)'(1);
    assign k_inc  = r_k + i8gemm_pkg::DCNT_W'(1);
    assign n_inc  = r_n + i8gemm_pkg::CCNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i8gemm_pkg::ST_IDLE;
            r_ec    <= '0;
            r_rc    <= '0;
            r_row   <= '0;
            r_mlast <= 1'b0;
            r_k     <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_ec    <= n_ec;
            r_rc    <= n_rc;
            r_row   <= n_row;
            r_mlast <= n_mlast;
            r_k     <= n_k;
            r_n     <= n_n;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ec    = r_ec;
        n_rc    = r_rc;
        n_row   = r_row;
        n_mlast = r_mlast;
        n_k     = r_k;
        n_n     = r_n;

        o_cmd             = '0;
        o_cmd.act_we      = is_act;
        o_cmd.act_waddr   = ec_eff[i8gemm_pkg::DEP_W-1:0];
        o_cmd.wgt_we      = accept && (i_op == i8gemm_pkg::OP_LOAD_WEIGHT);
        o_cmd.scale_we    = accept && (i_op == i8gemm_pkg::OP_LOAD_SCALE);
        o_cmd.rd_ch       = r_n[i8gemm_pkg::CH_W-1:0];
        o_cmd.rd_k        = r_k[i8gemm_pkg::DEP_W-1:0];
        o_cmd.row_number  = r_row;
        o_cmd.out_channel = r_n[i8gemm_pkg::CH_W-1:0];
        o_cmd.row_last    = (n_inc == i_cfg.chans);
        o_cmd.matrix_last = (n_inc == i_cfg.chans) && r_mlast;

        case (r_state)
            i8gemm_pkg::ST_IDLE: begin
                if (is_act) begin
                    if (ec_inc == i_cfg.depth) begin
                        // Row complete: latch its number and start the sweep
                        n_ec    = '0;
                        n_row   = rc_eff;
                        n_mlast = (rc_inc == {1'b0, i_cfg.rows});
                        n_rc    = (rc_inc >= {1'b0, i_cfg.rows}) ? '0
                                                                 : rc_inc[i8gemm_pkg::ROW_W-1:0];
                        n_k     = '0;
                        n_n     = '0;
                        n_state = i8gemm_pkg::ST_ACCUM;
                    end else begin
                        n_ec = ec_inc;
                    end
                end
            end
            i8gemm_pkg::ST_ACCUM: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.acc_clr = (r_k == '0);
                n_k           = k_inc;
                if (k_inc == i_cfg.depth) begin
                    n_state = i8gemm_pkg::ST_DRAIN;
                end
            end
            i8gemm_pkg::ST_DRAIN: begin
                n_state = i8gemm_pkg::ST_MAG;
            end
            i8gemm_pkg::ST_MAG: begin
                o_cmd.mag_en = 1'b1;
                n_state      = i8gemm_pkg::ST_LO;
            end
            i8gemm_pkg::ST_LO: begin
                o_cmd.lo_en = 1'b1;
                n_state     = i8gemm_pkg::ST_HI;
            end
            i8gemm_pkg::ST_HI: begin
                o_cmd.hi_en = 1'b1;
                n_state     = i8gemm_pkg::ST_SUM;
            end
            i8gemm_pkg::ST_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = i8gemm_pkg::ST_EMIT;
            end
            i8gemm_pkg::ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (n_inc == i_cfg.chans) begin
                    n_state = i8gemm_pkg::ST_IDLE;
                end else begin
                    n_n     = n_inc;
                    n_k     = '0;
                    n_state = i8gemm_pkg::ST_ACCUM;
                end
            end
            default: begin
                n_state = i8gemm_pkg::ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_emit_spaced, i_clk, i_rst_n, o_cmd.emit, !o_cmd.emit)
    `ASSERT_NEXT(a_row_end_idle, i_clk, i_rst_n, o_cmd.emit && o_cmd.row_last,
                 r_state == i8gemm_pkg::ST_IDLE)
    `ASSERT_IMPLIES(a_busy_from_row, i_clk, i_rst_n, $rose(o_busy), $past(is_act))
    `ASSERT_IMPLIES(a_chan_in_range, i_clk, i_rst_n, o_busy, r_n < i_cfg.chans)

endmodule

>>> rtl/core/int8_gemm_with_dequantization_core.sv
// ---------------------------------------------------------------------------
// int8_gemm_with_dequantization_core
// Signed-byte matrix-vector product with per-channel Q8.24 dequantization.
// ---------------------------------------------------------------------------
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+-------------------------------
//  request  | start, busy               | i_item (t_in_item)
//  result   | o_result_valid (strobe)   | o_result (t_out_item)
//  config   | i_cfg_we                  | i_cfg_idx, i_cfg_wdata
//
//  Loads, op 3 and activations that do not finish a row are taken with busy
//  low. A row-finishing activation raises busy while, for each channel, the
//  core runs the depth read/MAC sweep, then drain, magnitude, low and high
//  partial products, rounding sum and output register; each strobe is
//  registered together with that register. Synchronous active-low reset
//  clears counters, state and configuration, not the stores; no result stall.
// ---------------------------------------------------------------------------
module int8_gemm_with_dequantization_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  i8gemm_pkg::t_in_item              i_item,
    output logic                              o_result_valid,
    output i8gemm_pkg::t_out_item             o_result,
    input  logic                              i_cfg_we,
    input  logic [i8gemm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [i8gemm_pkg::SCALE_W-1:0]    i_cfg_wdata
);

    i8gemm_pkg::t_cfg    cfg;
    i8gemm_pkg::t_dp_cmd cmd;

    i8gemm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    i8gemm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_start (start),
        .i_op    (i_item.op),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    i8gemm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_item         (i_item),
        .i_cmd          (cmd),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule

>>> tb/tb_int8_gemm_with_dequantization_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_int8_gemm_with_dequantization_core
// Self-checking bench for the int8 GEMM core with per-channel dequantization.
// Loads weights and scales, streams activation rows and checks every channel
// result (row number, dot product, Q.16 dequantized value, last flags)
// against an in-bench prediction. Covers saturation, rounding ties, clamped
// register values, counter wrap, depth changes mid-row and random mixed
// traffic over several register settings.
// ----------------------------------------------------------------------------
module tb_int8_gemm_with_dequantization_core;

    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          PRELOAD_DEPTH  = 4;
    localparam logic [95:0] DQ_POS_LIMIT   = 96'h7FFF_FFFF_FFFF;
    localparam logic [95:0] DQ_NEG_LIMIT   = 96'h8000_0000_0000;
    localparam logic [31:0] SCALE_ONE      = 32'h0100_0000;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    i8gemm_pkg::t_in_item               req_item;
    logic                               res_valid;
    i8gemm_pkg::t_out_item              res_item;
    logic                               cfg_we;
    i8gemm_pkg::t_cfg_idx               cfg_idx;
    logic [i8gemm_pkg::SCALE_W-1:0]     cfg_wdata;

    // Predicted block state
    logic signed [i8gemm_pkg::VAL_W-1:0]
        wgt_mem [i8gemm_pkg::MAX_CHANNELS][i8gemm_pkg::MAX_DEPTH];
    logic [i8gemm_pkg::SCALE_W-1:0]      chan_scale [i8gemm_pkg::MAX_CHANNELS];
    logic signed [i8gemm_pkg::VAL_W-1:0] act_row_buf [i8gemm_pkg::MAX_DEPTH];
    int                                  elem_fill;
    int                                  row_index;
    logic [i8gemm_pkg::DCNT_W-1:0]       depth_reg;
    logic [i8gemm_pkg::CCNT_W-1:0]       chans_reg;
    logic [i8gemm_pkg::ROW_W-1:0]        rows_reg;
    logic [i8gemm_pkg::SCALE_W-1:0]      tensor_scale_reg;

    i8gemm_pkg::t_out_item pending_results [$];

    int  error_count;
    int  requests_accepted;
    int  rows_completed;
    int  results_checked;
    int  reg_writes;
    int  idle_cycles;
    bit  sender_gaps;

    int8_gemm_with_dequantization_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (req_item),
        .o_result_valid (res_valid),
        .o_result       (res_item),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        error_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic int clamp_count(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Round (dot * a * b / 2^32) to nearest, ties away from zero, saturate to 48 bits
    function automatic logic [i8gemm_pkg::DQ_W-1:0] dequant_q16(int dot,
                                                                logic [31:0] a_scale,
                                                                logic [31:0] c_scale);
        logic [95:0] mag;
        logic [95:0] prod;
        logic [95:0] rounded;
        logic        neg;
        neg     = dot < 0;
        mag     = neg ? 96'(-dot) : 96'(dot);
        prod    = 96'(a_scale) * 96'(c_scale);
        rounded = (mag * prod + 96'h8000_0000) >> 32;
        if (neg) begin
            if (rounded > DQ_NEG_LIMIT) rounded = DQ_NEG_LIMIT;
            rounded = -rounded;
        end else if (rounded > DQ_POS_LIMIT) begin
            rounded = DQ_POS_LIMIT;
        end
        return rounded[i8gemm_pkg::DQ_W-1:0];
    endfunction

    // Apply one accepted request and queue the channel results it produces
    function automatic void gemm_step(i8gemm_pkg::t_in_item it);
        int                    depth_eff;
        int                    chans_eff;
        int                    rows_eff;
        int                    dot;
        i8gemm_pkg::t_out_item r;
        depth_eff = clamp_count(int'(depth_reg), i8gemm_pkg::MAX_DEPTH);
        chans_eff = clamp_count(int'(chans_reg), i8gemm_pkg::MAX_CHANNELS);
        rows_eff  = clamp_count(int'(rows_reg), 65535);
        case (it.op)
            i8gemm_pkg::OP_LOAD_WEIGHT: wgt_mem[it.channel][it.depth_index] = it.value;
            i8gemm_pkg::OP_LOAD_SCALE:  chan_scale[it.channel] = it.scale_value;
            i8gemm_pkg::OP_ACTIVATION: begin
                // drop a partial row that no longer fits the depth
                if (elem_fill >= depth_eff) elem_fill = 0;
                act_row_buf[elem_fill] = it.value;
                elem_fill++;
                if (elem_fill < depth_eff) return;
                elem_fill = 0;
                if (row_index >= rows_eff) row_index = 0;
                for (int n = 0; n < chans_eff; n++) begin
                    dot = 0;
                    for (int k = 0; k < depth_eff; k++) begin
                        dot += int'(act_row_buf[k]) * int'(wgt_mem[n][k]);
                    end
                    r.row_number  = i8gemm_pkg::ROW_W'(row_index);
                    r.out_channel = i8gemm_pkg::CH_W'(n);
                    r.dot_sum     = i8gemm_pkg::SUM_W'(dot);
                    r.dequantized = dequant_q16(dot, tensor_scale_reg, chan_scale[n]);
                    r.row_last    = (n + 1 == chans_eff);
                    r.matrix_last = (n + 1 == chans_eff) && (row_index + 1 == rows_eff);
                    pending_results.push_back(r);
                end
                rows_completed++;
                row_index++;
                if (row_index >= rows_eff) row_index = 0;
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        i8gemm_pkg::t_out_item want;
        if (i_rst_n && res_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result: row %0d channel %0d",
                                          res_item.row_number, res_item.out_channel));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (res_item.row_number !== want.row_number)
                    report_mismatch($sformatf("row_number %0d, want %0d",
                                              res_item.row_number, want.row_number));
                if (res_item.out_channel !== want.out_channel)
                    report_mismatch($sformatf("out_channel %0d, want %0d",
                                              res_item.out_channel, want.out_channel));
                if (res_item.dot_sum !== want.dot_sum)
                    report_mismatch($sformatf("ch %0d dot_sum %0d, want %0d",
                                              want.out_channel, res_item.dot_sum,
                                              want.dot_sum));
                if (res_item.dequantized !== want.dequantized)
                    report_mismatch($sformatf("ch %0d dequantized %h, want %h",
                                              want.out_channel, res_item.dequantized,
                                              want.dequantized));
                if (res_item.row_last !== want.row_last)
                    report_mismatch($sformatf("ch %0d row_last %b, want %b",
                                              want.out_channel, res_item.row_last,
                                              want.row_last));
                if (res_item.matrix_last !== want.matrix_last)
                    report_mismatch($sformatf("ch %0d matrix_last %b, want %b",
                                              want.out_channel, res_item.matrix_last,
                                              want.matrix_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || res_valid || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it
    task automatic send_request(i8gemm_pkg::t_in_item it);
        if (sender_gaps && $urandom_range(0, 99) < 30) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start    <= 1'b1;
        req_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        requests_accepted++;
        gemm_step(it);
    endtask

    task automatic send_weight(int ch, int di, int val);
        i8gemm_pkg::t_in_item it;
        it.op          = i8gemm_pkg::OP_LOAD_WEIGHT;
        it.channel     = i8gemm_pkg::CH_W'(ch);
        it.depth_index = i8gemm_pkg::DEP_W'(di);
        it.value       = i8gemm_pkg::VAL_W'(val);
        it.scale_value = $urandom;
        send_request(it);
    endtask

    task automatic send_scale(int ch, logic [31:0] scale);
        i8gemm_pkg::t_in_item it;
        it.op          = i8gemm_pkg::OP_LOAD_SCALE;
        it.channel     = i8gemm_pkg::CH_W'(ch);
        it.depth_index = i8gemm_pkg::DEP_W'($urandom);
        it.value       = i8gemm_pkg::VAL_W'($urandom);
        it.scale_value = scale;
        send_request(it);
    endtask

    task automatic send_activation(int val);
        i8gemm_pkg::t_in_item it;
        it.op          = i8gemm_pkg::OP_ACTIVATION;
        it.channel     = i8gemm_pkg::CH_W'($urandom);
        it.depth_index = i8gemm_pkg::DEP_W'($urandom);
        it.value       = i8gemm_pkg::VAL_W'(val);
        it.scale_value = $urandom;
        send_request(it);
    endtask

    task automatic send_unused_op();
        i8gemm_pkg::t_in_item it;
        it             = i8gemm_pkg::t_in_item'({$urandom, $urandom});
        it.op          = OP_UNUSED;
        send_request(it);
    endtask

    // Drop start and wait until the block has delivered everything and gone idle
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(i8gemm_pkg::t_cfg_idx idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        reg_writes++;
        case (idx)
            i8gemm_pkg::CFG_DEPTH_USED:    depth_reg = data[i8gemm_pkg::DCNT_W-1:0];
            i8gemm_pkg::CFG_CHANNELS_USED: chans_reg = data[i8gemm_pkg::CCNT_W-1:0];
            i8gemm_pkg::CFG_ROWS:          rows_reg  = data[i8gemm_pkg::ROW_W-1:0];
            i8gemm_pkg::CFG_ACT_SCALE:     tensor_scale_reg = data;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int random_byte();
        case ($urandom_range(0, 9))
            0:       return -128;
            1:       return 127;
            default: return $urandom_range(0, 255) - 128;
        endcase
    endfunction

    // Preload every channel over the depths used below, saturate at both signs,
    // clamp over-range channel and depth counts
    task automatic test_saturation_and_clamps();
        write_reg(i8gemm_pkg::CFG_DEPTH_USED, 32'(PRELOAD_DEPTH));
        for (int ch = 0; ch < i8gemm_pkg::MAX_CHANNELS; ch++) begin
            for (int k = 0; k < PRELOAD_DEPTH; k++) begin
                case (ch)
                    0:       send_weight(ch, k, -128);
                    1:       send_weight(ch, k, 127);
                    2:       send_weight(ch, k, (k % 2) ? 127 : -128);
                    default: send_weight(ch, k, random_byte());
                endcase
            end
        end
        send_scale(0, 32'hFFFF_FFFF);
        send_scale(1, 32'hFFFF_FFFF);
        send_scale(2, 32'h0000_0000);
        send_scale(3, 32'h0000_0001);
        for (int ch = 4; ch < i8gemm_pkg::MAX_CHANNELS; ch++) send_scale(ch, $urandom);
        for (int k = 0; k < PRELOAD_DEPTH; k++) send_activation(-128);
        drain_results();
        // over-range channel count clamps to the maximum
        write_reg(i8gemm_pkg::CFG_CHANNELS_USED, 32'hFFFF_FFFF);
        write_reg(i8gemm_pkg::CFG_ACT_SCALE, 32'hFFFF_FFFF);
        for (int k = 0; k < PRELOAD_DEPTH; k++) send_activation(-128);
        for (int k = 0; k < PRELOAD_DEPTH; k++) send_activation(127);
        for (int k = 0; k < PRELOAD_DEPTH; k++) send_activation(random_byte());
        drain_results();
        // over-range depth acts as the full depth: a short row stays open
        write_reg(i8gemm_pkg::CFG_DEPTH_USED, 32'h0000_01FF);
        repeat (PRELOAD_DEPTH - 1) send_activation(random_byte());
        drain_results();
        // the open row continues under the smaller depth
        write_reg(i8gemm_pkg::CFG_DEPTH_USED, 32'(PRELOAD_DEPTH));
        send_activation(random_byte());
        drain_results();
    endtask

    task automatic test_rounding_ties();
        write_reg(i8gemm_pkg::CFG_DEPTH_USED, 32'd1);
        write_reg(i8gemm_pkg::CFG_CHANNELS_USED, 32'd2);
        write_reg(i8gemm_pkg::CFG_ROWS, 32'd65535);
        write_reg(i8gemm_pkg::CFG_ACT_SCALE, SCALE_ONE);
        send_weight(0, 0, 1);
        send_weight(1, 0, -1);
        send_weight(15, 255, 127);
        send_scale(0, 32'h0000_0080);   // product lands exactly on a half
        send_scale(1, 32'h0000_00C0);   // three quarters
        send_scale(15, 32'hFFFF_FFFF);
        send_activation(1);
        send_activation(-1);
        send_unused_op();
        send_activation(3);
        send_activation(-3);
        send_activation(127);
        send_activation(-128);
        drain_results();
    endtask

    // Zero in every count register acts as one
    task automatic test_zero_registers();
        write_reg(i8gemm_pkg::CFG_DEPTH_USED, 32'hFFFF_FE00);
        write_reg(i8gemm_pkg::CFG_CHANNELS_USED, 32'hFFFF_FFE0);
        write_reg(i8gemm_pkg::CFG_ROWS, 32'hFFFF_0000);
        write_reg(i8gemm_pkg::CFG_ACT_SCALE, 32'h0000_0000);
        send_activation(-128);
        send_activation(127);
        send_unused_op();
        send_activation(0);
        drain_results();
    endtask

    task automatic test_row_wrap();
        write_reg(i8gemm_pkg::CFG_DEPTH_USED, 32'd2);
        write_reg(i8gemm_pkg::CFG_CHANNELS_USED, 32'd3);
        write_reg(i8gemm_pkg::CFG_ROWS, 32'd5);
        write_reg(i8gemm_pkg::CFG_ACT_SCALE, SCALE_ONE);
        repeat (6) send_activation(random_byte());
        drain_results();
        // row counter now beyond the new row count: wraps before the next row
        write_reg(i8gemm_pkg::CFG_ROWS, 32'd2);
        repeat (4) send_activation(random_byte());
        drain_results();
    endtask

    task automatic test_depth_change_mid_row();
        write_reg(i8gemm_pkg::CFG_DEPTH_USED, 32'd6);
        write_reg(i8gemm_pkg::CFG_CHANNELS_USED, 32'd2);
        repeat (4) send_activation(random_byte());
        drain_results();
        write_reg(i8gemm_pkg::CFG_DEPTH_USED, 32'd3);
        repeat (3) send_activation(random_byte());
        drain_results();
        write_reg(i8gemm_pkg::CFG_DEPTH_USED, 32'd2);
        send_activation(random_byte());
        drain_results();
        write_reg(i8gemm_pkg::CFG_DEPTH_USED, 32'd4);
        repeat (3) send_activation(random_byte());
        drain_results();
    endtask

    task automatic run_random_phase(int n_items, bit gaps);
        int          depth_val;
        int          rows_val;
        logic [31:0] ascale;
        int          pick;
        drain_results();
        sender_gaps = gaps;
        depth_val = $urandom_range(1, PRELOAD_DEPTH);
        case ($urandom_range(0, 3))
            0:       rows_val = 0;
            1:       rows_val = 65535;
            default: rows_val = $urandom_range(1, 6);
        endcase
        case ($urandom_range(0, 4))
            0:       ascale = 32'h0000_0000;
            1:       ascale = SCALE_ONE;
            2:       ascale = 32'hFFFF_FFFF;
            3:       ascale = $urandom_range(1, 32'h00FF_FFFF);
            default: ascale = $urandom;
        endcase
        // upper bits beyond each register's width are noise
        write_reg(i8gemm_pkg::CFG_DEPTH_USED, ($urandom & ~32'h1FF) | 32'(depth_val));
        write_reg(i8gemm_pkg::CFG_CHANNELS_USED,
                  ($urandom & ~32'h1F) | 32'($urandom_range(1, 16)));
        write_reg(i8gemm_pkg::CFG_ROWS, ($urandom & ~32'hFFFF) | 32'(rows_val));
        write_reg(i8gemm_pkg::CFG_ACT_SCALE, ascale);
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2 && $urandom_range(0, 1) == 0) drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_activation(random_byte());
            end else if (pick < 85) begin
                send_weight($urandom_range(0, 15),
                            ($urandom_range(0, 9) < 7) ? $urandom_range(0, depth_val - 1)
                                                       : $urandom_range(0, 255),
                            random_byte());
            end else if (pick < 95) begin
                send_scale($urandom_range(0, 15), $urandom);
            end else begin
                send_unused_op();
            end
        end
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 4; p++) begin
            // one phase runs back to back with no sender gaps
            run_random_phase(30, p != 2);
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        start            = 1'b0;
        req_item         = '0;
        cfg_we           = 1'b0;
        cfg_idx          = i8gemm_pkg::CFG_DEPTH_USED;
        cfg_wdata        = '0;
        sender_gaps      = 1'b1;
        error_count      = 0;
        idle_cycles      = 0;
        elem_fill        = 0;
        row_index        = 0;
        depth_reg        = i8gemm_pkg::DEPTH_RST;
        chans_reg        = i8gemm_pkg::CHANS_RST;
        rows_reg         = i8gemm_pkg::ROWS_RST;
        tensor_scale_reg = i8gemm_pkg::ASCALE_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_saturation_and_clamps();
        test_rounding_ties();
        test_zero_registers();
        test_row_wrap();
        test_depth_change_mid_row();
        test_random_traffic();

        drain_results();
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        $display("Run covered %0d requests, %0d completed rows, %0d channel results checked,",
                 requests_accepted, rows_completed, results_checked);
        $display("%0d register writes incl. clamped, zero and wrap settings; %0d errors",
                 reg_writes, error_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/i8gemm_pkg.sv
rtl/core/i8gemm_cfg.sv
rtl/core/i8gemm_dp.sv
rtl/core/i8gemm_ctrl.sv
rtl/core/int8_gemm_with_dequantization_core.sv
tb/tb_int8_gemm_with_dequantization_core.sv
